// ----- hdl/ebalu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ebalu_pkg;

  localparam int CMD_W  = 4;
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;
  localparam int NIB_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD8  = 4'd0,
    OP_SUB8  = 4'd1,
    OP_ADD16 = 4'd2,
    OP_SUB16 = 4'd3,
    OP_AND8  = 4'd4,
    OP_OR8   = 4'd5,
    OP_XOR8  = 4'd6,
    OP_INC8  = 4'd7,
    OP_DEC8  = 4'd8
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              flag_zero;
    logic              flag_subtract;
    logic              flag_half;
    logic              flag_carry;
    logic              carry_updated;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/ebalu_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ebalu_in_if;
  logic                         valid;
  logic                         ready;
  logic [ebalu_pkg::CMD_W-1:0]  cmd;
  logic [ebalu_pkg::WORD_W-1:0] operand_a;
  logic [ebalu_pkg::WORD_W-1:0] operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input cmd, input operand_a, input operand_b,
                output ready);
endinterface

`default_nettype wire

// ----- hdl/ebalu_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ebalu_out_if;
  logic                         valid;
  logic                         ready;
  logic [ebalu_pkg::WORD_W-1:0] result;
  logic                         flag_zero;
  logic                         flag_subtract;
  logic                         flag_half;
  logic                         flag_carry;
  logic                         carry_updated;

  modport source (output valid, output result, output flag_zero, output flag_subtract,
                  output flag_half, output flag_carry, output carry_updated,
                  input ready);
  modport sink (input valid, input result, input flag_zero, input flag_subtract,
                input flag_half, input flag_carry, input carry_updated,
                output ready);
endinterface

`default_nettype wire

// ----- hdl/ebalu_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ebalu_core (
  input  var ebalu_pkg::req_t req,
  output var ebalu_pkg::res_t res
);

  logic [ebalu_pkg::BYTE_W-1:0] a8;
  logic [ebalu_pkg::BYTE_W-1:0] b8;
  logic [ebalu_pkg::BYTE_W:0]   sum8;
  logic [ebalu_pkg::BYTE_W:0]   diff8;
  logic [ebalu_pkg::WORD_W:0]   sum16;
  logic [ebalu_pkg::WORD_W:0]   diff16;
  logic [ebalu_pkg::NIB_W:0]    nib_sum;
  logic [ebalu_pkg::NIB_W:0]    nib_diff;
  logic [ebalu_pkg::BYTE_W-1:0] inc8;
  logic [ebalu_pkg::BYTE_W-1:0] dec8;
  logic [ebalu_pkg::NIB_W-1:0]  a_nib;
  logic [ebalu_pkg::WORD_W-1:0] res_word;
  logic                         known;

  assign a8    = req.operand_a[ebalu_pkg::BYTE_W-1:0];
  assign b8    = req.operand_b[ebalu_pkg::BYTE_W-1:0];
  assign a_nib = req.operand_a[ebalu_pkg::NIB_W-1:0];

  assign sum8   = {1'b0, a8} + {1'b0, b8};
  assign diff8  = {1'b0, a8} - {1'b0, b8};
  assign sum16  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign diff16 = {1'b0, req.operand_a} - {1'b0, req.operand_b};
  // Both widths take their half flag from the low nibble.
  assign nib_sum  = {1'b0, a_nib} + {1'b0, req.operand_b[ebalu_pkg::NIB_W-1:0]};
  assign nib_diff = {1'b0, a_nib} - {1'b0, req.operand_b[ebalu_pkg::NIB_W-1:0]};
  assign inc8 = a8 + 8'd1;
  assign dec8 = a8 - 8'd1;

  always_comb begin
    res_word          = '0;
    known             = 1'b1;
    res.flag_subtract = 1'b0;
    res.flag_half     = 1'b0;
    res.flag_carry    = 1'b0;
    res.carry_updated = 1'b1;
    unique case (req.cmd)
      ebalu_pkg::OP_ADD8: begin
        res_word       = {8'd0, sum8[ebalu_pkg::BYTE_W-1:0]};
        res.flag_carry = sum8[ebalu_pkg::BYTE_W];
        res.flag_half  = nib_sum[ebalu_pkg::NIB_W];
      end
      ebalu_pkg::OP_SUB8: begin
        res_word          = {8'd0, diff8[ebalu_pkg::BYTE_W-1:0]};
        res.flag_subtract = 1'b1;
        res.flag_carry    = diff8[ebalu_pkg::BYTE_W];
        res.flag_half     = nib_diff[ebalu_pkg::NIB_W];
      end
      ebalu_pkg::OP_ADD16: begin
        res_word       = sum16[ebalu_pkg::WORD_W-1:0];
        res.flag_carry = sum16[ebalu_pkg::WORD_W];
        res.flag_half  = nib_sum[ebalu_pkg::NIB_W];
      end
      ebalu_pkg::OP_SUB16: begin
        res_word          = diff16[ebalu_pkg::WORD_W-1:0];
        res.flag_subtract = 1'b1;
        res.flag_carry    = diff16[ebalu_pkg::WORD_W];
        res.flag_half     = nib_diff[ebalu_pkg::NIB_W];
      end
      ebalu_pkg::OP_AND8: begin
        res_word      = {8'd0, a8 & b8};
        res.flag_half = 1'b1;
      end
      ebalu_pkg::OP_OR8: begin
        res_word = {8'd0, a8 | b8};
      end
      ebalu_pkg::OP_XOR8: begin
        res_word = {8'd0, a8 ^ b8};
      end
      ebalu_pkg::OP_INC8: begin
        res_word          = {8'd0, inc8};
        res.flag_half     = (a_nib == 4'hF);
        res.carry_updated = 1'b0;
      end
      ebalu_pkg::OP_DEC8: begin
        res_word          = {8'd0, dec8};
        res.flag_subtract = 1'b1;
        res.flag_half     = (a_nib == 4'h0);
        res.carry_updated = 1'b0;
      end
      default: begin
        // Unused codes return all zeros, zero flag included.
        known             = 1'b0;
        res.carry_updated = 1'b0;
      end
    endcase
    res.result    = res_word;
    res.flag_zero = known && (res_word == '0);
  end

endmodule

`default_nettype wire

// ----- hdl/eight_bit_cpu_alu_with_flags.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Path: a request beat is taken into the input register, passes the ALU logic and
//   is offered from the result register; each register holds one beat.
// Throughput: one operation per cycle unless rsp.ready stalls the result register;
//   the ALU logic between the two registers is a single pass.
// Reset (rst, synchronous, active high) empties both registers; data bits are
//   not reset.
module eight_bit_cpu_alu_with_flags (
  input  wire          clk,
  input  wire          rst,
  ebalu_in_if.sink     req,
  ebalu_out_if.source  rsp
);

  ebalu_pkg::req_t req_beat;
  ebalu_pkg::req_t op_reg;
  ebalu_pkg::res_t core_res;
  ebalu_pkg::res_t res_reg;
  logic            op_valid;
  logic            res_valid;
  logic            op_advance;
  logic            res_load;

  assign req_beat.cmd       = req.cmd;
  assign req_beat.operand_a = req.operand_a;
  assign req_beat.operand_b = req.operand_b;

  // Result stage frees up when empty or when its beat is taken this cycle.
  assign res_load   = !res_valid || rsp.ready;
  assign op_advance = op_valid && res_load;
  assign req.ready  = !op_valid || res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (req.ready) begin
      op_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      op_reg <= req_beat;
    end
  end

  ebalu_core u_core (
    .req (op_reg),
    .res (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_advance) begin
      res_reg <= core_res;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.result        = res_reg.result;
  assign rsp.flag_zero     = res_reg.flag_zero;
  assign rsp.flag_subtract = res_reg.flag_subtract;
  assign rsp.flag_half     = res_reg.flag_half;
  assign rsp.flag_carry    = res_reg.flag_carry;
  assign rsp.carry_updated = res_reg.carry_updated;

  a_accept_loads_op : assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> op_valid)
    else $error("accepted request beat did not reach the operand register");

  a_advance_loads_res : assert property (@(posedge clk) disable iff (rst)
    op_advance |=> res_valid)
    else $error("operand beat advanced but no result beat followed");

  a_held_op_stays : assert property (@(posedge clk) disable iff (rst)
    op_valid && !res_load |=> op_valid && $stable(op_reg))
    else $error("stalled operand beat was lost or changed");

  a_zero_matches : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_reg.flag_zero |-> res_reg.result == '0)
    else $error("zero flag set on a nonzero result");

  a_kept_carry_clear : assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_reg.carry_updated |-> !res_reg.flag_carry)
    else $error("carry reported on an operation that keeps carry");

endmodule

`default_nettype wire

// ----- test/tb_eight_bit_cpu_alu_with_flags.sv -----
`timescale 1ns / 1ps

module tb_eight_bit_cpu_alu_with_flags;

  localparam int unsigned IDLE_PCT     = 16;
  localparam int unsigned RANDOM_OPS   = 1425;
  localparam int unsigned CALM_FIRST   = 600;
  localparam int unsigned CALM_LAST    = 899;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [ebalu_pkg::CMD_W-1:0] CMD_SPARE_LO = 4'd9;
  localparam logic [ebalu_pkg::CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  // Holds the flag results each accepted operation should produce, oldest first.
  class alu_scoreboard;
    ebalu_pkg::res_t flags_q[$];
    int unsigned     errors;

    function new();
      errors = 0;
    endfunction

    function ebalu_pkg::res_t compute_flags(ebalu_pkg::req_t op);
      logic [ebalu_pkg::BYTE_W-1:0] a8;
      logic [ebalu_pkg::BYTE_W-1:0] b8;
      logic [ebalu_pkg::BYTE_W:0]   sum9;
      logic [ebalu_pkg::WORD_W:0]   sum17;
      logic [ebalu_pkg::NIB_W:0]    nib5;
      logic                         known;
      ebalu_pkg::res_t              r;
      a8    = op.operand_a[ebalu_pkg::BYTE_W-1:0];
      b8    = op.operand_b[ebalu_pkg::BYTE_W-1:0];
      nib5  = {1'b0, op.operand_a[ebalu_pkg::NIB_W-1:0]}
            + {1'b0, op.operand_b[ebalu_pkg::NIB_W-1:0]};
      known = 1'b1;
      r     = '0;
      r.carry_updated = 1'b1;
      unique case (op.cmd)
        ebalu_pkg::OP_ADD8: begin
          sum9         = {1'b0, a8} + {1'b0, b8};
          r.result     = {8'h00, sum9[ebalu_pkg::BYTE_W-1:0]};
          r.flag_carry = sum9[ebalu_pkg::BYTE_W];
          r.flag_half  = nib5[ebalu_pkg::NIB_W];
        end
        ebalu_pkg::OP_SUB8: begin
          r.result        = {8'h00, 8'(a8 - b8)};
          r.flag_subtract = 1'b1;
          r.flag_carry    = a8 < b8;
          r.flag_half     = a8[ebalu_pkg::NIB_W-1:0] < b8[ebalu_pkg::NIB_W-1:0];
        end
        ebalu_pkg::OP_ADD16: begin
          sum17        = {1'b0, op.operand_a} + {1'b0, op.operand_b};
          r.result     = sum17[ebalu_pkg::WORD_W-1:0];
          r.flag_carry = sum17[ebalu_pkg::WORD_W];
          r.flag_half  = nib5[ebalu_pkg::NIB_W];
        end
        ebalu_pkg::OP_SUB16: begin
          r.result        = op.operand_a - op.operand_b;
          r.flag_subtract = 1'b1;
          r.flag_carry    = op.operand_a < op.operand_b;
          r.flag_half     = op.operand_a[ebalu_pkg::NIB_W-1:0]
                          < op.operand_b[ebalu_pkg::NIB_W-1:0];
        end
        ebalu_pkg::OP_AND8: begin
          r.result    = {8'h00, a8 & b8};
          r.flag_half = 1'b1;
        end
        ebalu_pkg::OP_OR8:  r.result = {8'h00, a8 | b8};
        ebalu_pkg::OP_XOR8: r.result = {8'h00, a8 ^ b8};
        ebalu_pkg::OP_INC8: begin
          r.result        = {8'h00, 8'(a8 + 8'd1)};
          r.flag_half     = a8[ebalu_pkg::NIB_W-1:0] == 4'hF;
          r.carry_updated = 1'b0;
        end
        ebalu_pkg::OP_DEC8: begin
          r.result        = {8'h00, 8'(a8 - 8'd1)};
          r.flag_subtract = 1'b1;
          r.flag_half     = a8[ebalu_pkg::NIB_W-1:0] == 4'h0;
          r.carry_updated = 1'b0;
        end
        default: begin
          known           = 1'b0;
          r.carry_updated = 1'b0;
        end
      endcase
      r.flag_zero = known && (r.result == '0);
      return r;
    endfunction

    function void note_request(ebalu_pkg::req_t op);
      flags_q.push_back(compute_flags(op));
    endfunction

    function void compare_field(string name, logic [ebalu_pkg::WORD_W-1:0] want,
                                logic [ebalu_pkg::WORD_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void compare_bit(string name, logic want, logic got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
      end
    endfunction

    function void check_result(ebalu_pkg::res_t got);
      ebalu_pkg::res_t want;
      if (flags_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual %h", $time, got);
        return;
      end
      want = flags_q.pop_front();
      compare_field("result", want.result, got.result);
      compare_bit("flag_zero", want.flag_zero, got.flag_zero);
      compare_bit("flag_subtract", want.flag_subtract, got.flag_subtract);
      compare_bit("flag_half", want.flag_half, got.flag_half);
      compare_bit("flag_carry", want.flag_carry, got.flag_carry);
      compare_bit("carry_updated", want.carry_updated, got.carry_updated);
    endfunction

    function int unsigned pending();
      return flags_q.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          calm;
  int unsigned   stall_cycles;
  alu_scoreboard flags_sb;

  ebalu_in_if  req_if ();
  ebalu_out_if rsp_if ();

  eight_bit_cpu_alu_with_flags u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: stall at random unless inside the calm stretch.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready = calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    ebalu_pkg::req_t op;
    ebalu_pkg::res_t got;
    if (!rst) begin
      op.cmd       = req_if.cmd;
      op.operand_a = req_if.operand_a;
      op.operand_b = req_if.operand_b;
      got.result        = rsp_if.result;
      got.flag_zero     = rsp_if.flag_zero;
      got.flag_subtract = rsp_if.flag_subtract;
      got.flag_half     = rsp_if.flag_half;
      got.flag_carry    = rsp_if.flag_carry;
      got.carry_updated = rsp_if.carry_updated;
      if (req_if.valid && req_if.ready)
        flags_sb.note_request(op);
      if (rsp_if.valid && rsp_if.ready)
        flags_sb.check_result(got);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_op(input logic [ebalu_pkg::CMD_W-1:0] cmd,
                         input logic [ebalu_pkg::WORD_W-1:0] a,
                         input logic [ebalu_pkg::WORD_W-1:0] b);
    while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid     = 1'b1;
    req_if.cmd       = cmd;
    req_if.operand_a = a;
    req_if.operand_b = b;
    @(posedge clk);
    while (!req_if.ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Favor carry and nibble boundaries alongside fully random words.
  function automatic logic [ebalu_pkg::WORD_W-1:0] pick_operand();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {8'($urandom), 8'h00};
      3:       return {8'($urandom), 8'hFF};
      4:       return {12'($urandom), 4'hF};
      5:       return {12'($urandom), 4'h0};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [ebalu_pkg::CMD_W-1:0] cmd;
    flags_sb         = new();
    stall_cycles     = 0;
    calm             = 1'b0;
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.cmd       = ebalu_pkg::OP_ADD8;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_op(ebalu_pkg::OP_ADD8, 16'h00FF, 16'h0001);
    send_op(ebalu_pkg::OP_ADD8, 16'h000F, 16'h0001);
    send_op(ebalu_pkg::OP_ADD8, 16'hABFF, 16'hCD00);
    send_op(ebalu_pkg::OP_SUB8, 16'h0000, 16'h0001);
    send_op(ebalu_pkg::OP_SUB8, 16'h0010, 16'h0001);
    send_op(ebalu_pkg::OP_SUB8, 16'hFF5A, 16'h005A);
    send_op(ebalu_pkg::OP_ADD16, 16'hFFFF, 16'h0001);
    send_op(ebalu_pkg::OP_ADD16, 16'h000F, 16'h0001);
    send_op(ebalu_pkg::OP_ADD16, 16'h8000, 16'h8000);
    send_op(ebalu_pkg::OP_SUB16, 16'h0000, 16'h0001);
    send_op(ebalu_pkg::OP_SUB16, 16'h1234, 16'h1234);
    send_op(ebalu_pkg::OP_SUB16, 16'h0010, 16'h0001);
    send_op(ebalu_pkg::OP_AND8, 16'h00F0, 16'h000F);
    send_op(ebalu_pkg::OP_AND8, 16'hFFFF, 16'hFFFF);
    send_op(ebalu_pkg::OP_OR8, 16'hFF00, 16'hFF00);
    send_op(ebalu_pkg::OP_OR8, 16'h00AA, 16'h0055);
    send_op(ebalu_pkg::OP_XOR8, 16'h00FF, 16'h00FF);
    send_op(ebalu_pkg::OP_XOR8, 16'h5AC3, 16'hA53C);
    send_op(ebalu_pkg::OP_INC8, 16'h00FF, 16'hFFFF);
    send_op(ebalu_pkg::OP_INC8, 16'h120F, 16'h0000);
    send_op(ebalu_pkg::OP_DEC8, 16'h0000, 16'hFFFF);
    send_op(ebalu_pkg::OP_DEC8, 16'hFF01, 16'h0000);
    send_op(ebalu_pkg::OP_DEC8, 16'h0010, 16'h1234);
    send_op(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF);
    send_op(CMD_SPARE_HI, 16'h0000, 16'h0000);

    for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
      calm = (i >= CALM_FIRST) && (i <= CALM_LAST);
      if ($urandom_range(99) < 6)
        cmd = 4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      else
        cmd = 4'($urandom_range(ebalu_pkg::OP_DEC8));
      send_op(cmd, pick_operand(), pick_operand());
    end
    req_if.valid = 1'b0;
    calm         = 1'b0;

    while (flags_sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (flags_sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
